FILE: rtl/core/efb_pkg.sv
// ----------------------------------------------------------------------------
// efb_pkg
// Shared types and constants for the escaped frame builder: configuration
// fields, queue entry layout and the output sequencer steps.
// ----------------------------------------------------------------------------
package efb_pkg;

  localparam int BYTE_W     = 8;
  localparam int CRC_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);

  localparam logic [CRC_W-1:0]  CRC_POLY = 16'h8408;
  localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;

  localparam logic [BYTE_W-1:0] START_RST = 8'hF0;
  localparam logic [BYTE_W-1:0] STOP_RST  = 8'hF1;
  localparam logic [BYTE_W-1:0] ESC_RST   = 8'hF2;
  localparam logic [BYTE_W-1:0] MASK_RST  = 8'hFF;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START  = 2'd0,
    CFG_STOP   = 2'd1,
    CFG_ESC    = 2'd2,
    CFG_MASK   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] stop_marker;
    logic [BYTE_W-1:0] escape_marker;
    logic [BYTE_W-1:0] escape_mask;
  } cfg_t;

  // one classified input word, as queued between front and back
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
    logic [CRC_W-1:0]  crc_fin;
    logic              esc_data;
    logic              esc_hi;
    logic              esc_lo;
  } entry_t;

  // output sequencer steps
  typedef enum logic [2:0] {
    ST_START    = 3'd0,
    ST_DATA_ESC = 3'd1,
    ST_DATA     = 3'd2,
    ST_HI_ESC   = 3'd3,
    ST_HI       = 3'd4,
    ST_LO_ESC   = 3'd5,
    ST_LO       = 3'd6,
    ST_STOP     = 3'd7
  } step_t;

endpackage

FILE: rtl/core/efb_front.sv
// ----------------------------------------------------------------------------
// efb_front
// Input side: runs the CRC over payload bytes and classifies each word
// (escape needs of the byte and of the closing CRC bytes) for the queue.
// ----------------------------------------------------------------------------
module efb_front (
  input  logic                       clk,
  input  logic                       rst,
  input  efb_pkg::cfg_t              cfg,
  input  logic                       accept,
  input  logic [efb_pkg::BYTE_W-1:0] in_byte,
  input  logic                       byte_kind,
  input  logic                       packet_first,
  input  logic                       packet_last,
  output efb_pkg::entry_t            entry
);
  import efb_pkg::*;

  logic [CRC_W-1:0] crc_reg;
  logic [CRC_W-1:0] crc_base;
  logic [CRC_W-1:0] crc_new;
  logic [CRC_W-1:0] crc_fin;

  // one reflected crc byte step, eight bit steps
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                input logic [BYTE_W-1:0] d);
    logic [CRC_W-1:0] c;
    c = c_in;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[0] ^ d[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic needs_esc(input logic [BYTE_W-1:0] b, input cfg_t c);
    return (b == c.start_marker) || (b == c.stop_marker) || (b == c.escape_marker);
  endfunction

  // crc path
  always_comb begin
    crc_base = packet_first ? CRC_INIT : crc_reg;
    crc_new  = byte_kind ? crc_byte(crc_base, in_byte) : crc_base;
    crc_fin  = ~crc_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg <= CRC_INIT;
    end else if (accept) begin
      crc_reg <= packet_last ? CRC_INIT : crc_new;
    end
  end

  // classified word
  always_comb begin
    entry.data     = in_byte;
    entry.first    = packet_first;
    entry.last     = packet_last;
    entry.crc_fin  = crc_fin;
    entry.esc_data = needs_esc(in_byte, cfg);
    entry.esc_hi   = needs_esc(crc_fin[CRC_W-1:BYTE_W], cfg);
    entry.esc_lo   = needs_esc(crc_fin[BYTE_W-1:0], cfg);
  end

endmodule

FILE: rtl/core/efb_queue.sv
// ----------------------------------------------------------------------------
// efb_queue
// Small queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module efb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  efb_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output efb_pkg::entry_t head
);
  import efb_pkg::*;

  entry_t         mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full      = (count == QDEPTH[QAW:0]);
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("queue read while empty");

endmodule

FILE: rtl/core/efb_back.sv
// ----------------------------------------------------------------------------
// efb_back
// Output side: steps through the line bytes of the current word (start
// marker, escaped byte, escaped crc bytes, stop marker) into an output register.
// ----------------------------------------------------------------------------
module efb_back (
  input  logic                       clk,
  input  logic                       rst,
  input  efb_pkg::cfg_t              cfg,
  input  logic                       q_valid,
  input  efb_pkg::entry_t            q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [efb_pkg::BYTE_W-1:0] out_byte,
  output logic                       run_last,
  output logic                       frame_end
);
  import efb_pkg::*;

  entry_t            cur;
  logic              cur_valid;
  step_t             step;
  step_t             step_next;
  step_t             load_step;
  logic              done;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;

  assign emit  = cur_valid && (!out_valid || out_ready);
  assign q_pop = q_valid && (!cur_valid || (emit && done));

  // first step of a freshly loaded word
  always_comb begin
    if (q_head.first) begin
      load_step = ST_START;
    end else if (q_head.esc_data) begin
      load_step = ST_DATA_ESC;
    end else begin
      load_step = ST_DATA;
    end
  end

  // next step and byte for the current step
  always_comb begin
    step_next = step;
    done      = 1'b0;
    emit_byte = cur.data;
    case (step)
      ST_START: begin
        emit_byte = cfg.start_marker;
        step_next = cur.esc_data ? ST_DATA_ESC : ST_DATA;
      end
      ST_DATA_ESC: begin
        emit_byte = cfg.escape_marker;
        step_next = ST_DATA;
      end
      ST_DATA: begin
        emit_byte = cur.esc_data ? (cur.data ^ cfg.escape_mask) : cur.data;
        step_next = cur.esc_hi ? ST_HI_ESC : ST_HI;
        done      = !cur.last;
      end
      ST_HI_ESC: begin
        emit_byte = cfg.escape_marker;
        step_next = ST_HI;
      end
      ST_HI: begin
        emit_byte = cur.esc_hi ? (cur.crc_fin[CRC_W-1:BYTE_W] ^ cfg.escape_mask)
                               : cur.crc_fin[CRC_W-1:BYTE_W];
        step_next = cur.esc_lo ? ST_LO_ESC : ST_LO;
      end
      ST_LO_ESC: begin
        emit_byte = cfg.escape_marker;
        step_next = ST_LO;
      end
      ST_LO: begin
        emit_byte = cur.esc_lo ? (cur.crc_fin[BYTE_W-1:0] ^ cfg.escape_mask)
                               : cur.crc_fin[BYTE_W-1:0];
        step_next = ST_STOP;
      end
      ST_STOP: begin
        emit_byte = cfg.stop_marker;
        done      = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  // current word and step
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= ST_DATA;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      step      <= load_step;
    end else if (emit) begin
      cur_valid <= !done;
      step      <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= emit_byte;
      run_last  <= done;
      frame_end <= (step == ST_STOP);
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> run_last) else $error("stop marker not last of run");
  a_crc_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && (step == ST_HI_ESC || step == ST_HI || step == ST_LO_ESC ||
                   step == ST_LO || step == ST_STOP)) |-> cur.last)
    else $error("trailer step on a word that does not close the packet");

endmodule

FILE: rtl/core/escaped_frame_builder_crc16.sv
// ----------------------------------------------------------------------------
// escaped_frame_builder_crc16
// Byte stuffing framer with CRC-16/X-25 over the payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one packet byte per word with its
//   kind (header or payload) and first/last marks. Output channel
//   (out_valid/out_ready) gives one line byte per word; run_last marks the
//   last line byte caused by an input word, frame_end the closing stop marker.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the start,
//   stop and escape markers and the escape mask; write it only while idle.
// Path: an accepted input word is written into the queue, loaded into the
//   current word register, and each line byte is registered on output.
// Throughput: while out_ready is high and a word is ready, the output sequencer
//   gives one line byte per cycle; an input word expands to 1 to 8 line bytes:
//   its data byte plus, as needed, start marker, escape bytes, two crc bytes
//   and stop marker. A four-word queue lets the input run ahead of the sequencer.
// Reset: markers return to 0xF0/0xF1/0xF2, mask to 0xFF, crc to 0xFFFF,
//   queue and output register empty.
// Stall: while out_ready is low the output word holds; the queue fills and
//   in_ready drops once it is full.
// ----------------------------------------------------------------------------
module escaped_frame_builder_crc16 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [efb_pkg::BYTE_W-1:0]    in_byte,
  input  logic                          byte_kind,
  input  logic                          packet_first,
  input  logic                          packet_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [efb_pkg::BYTE_W-1:0]    out_byte,
  output logic                          run_last,
  output logic                          frame_end,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [efb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [efb_pkg::BYTE_W-1:0]    cfg_data
);
  import efb_pkg::*;

  cfg_t   cfg;
  entry_t fe_entry;
  entry_t q_head;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;
  logic   in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker  <= START_RST;
      cfg.stop_marker   <= STOP_RST;
      cfg.escape_marker <= ESC_RST;
      cfg.escape_mask   <= MASK_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START: cfg.start_marker  <= cfg_data;
        CFG_STOP:  cfg.stop_marker   <= cfg_data;
        CFG_ESC:   cfg.escape_marker <= cfg_data;
        CFG_MASK:  cfg.escape_mask   <= cfg_data;
        default:   cfg.escape_mask   <= cfg.escape_mask;
      endcase
    end
  end

  efb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (in_accept),
    .in_byte      (in_byte),
    .byte_kind    (byte_kind),
    .packet_first (packet_first),
    .packet_last  (packet_last),
    .entry        (fe_entry)
  );

  efb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept),
    .push_data (fe_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  efb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .frame_end (frame_end)
  );

endmodule
